[hdl/mfbi_pkg.sv]
// Shared types and constants for the multichannel FIR block integrator.
// Holds sizes, register indexes, mode codes, controller states and the
// command/status structs. No dependencies.
package mfbi_pkg;

  localparam int CHANNELS       = 16;
  localparam int TAPS           = 64;
  localparam int MAX_BLOCK      = 256;
  localparam int COEF_FRAC_BITS = 14;

  localparam int CH_W     = 4;
  localparam int TAP_W    = 6;
  localparam int TAPCNT_W = 7;
  localparam int MEM_DEPTH = CHANNELS * TAPS;
  localparam int MEM_AW    = $clog2(MEM_DEPTH);

  localparam logic [1:0] REG_MODE  = 2'd0;
  localparam logic [1:0] REG_TAPS  = 2'd1;
  localparam logic [1:0] REG_CHANS = 2'd2;
  localparam logic [1:0] REG_BLEN  = 2'd3;

  localparam logic [1:0] MODE_NONE = 2'd0;
  localparam logic [1:0] MODE_MEAN = 2'd1;
  localparam logic [1:0] MODE_RMS  = 2'd2;
  localparam logic [1:0] MODE_MAX  = 2'd3;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_DEC, S_MAC, S_DRAIN, S_FILT,
    S_DIV, S_SQLD, S_SQRT, S_RES, S_DONE
  } state_e;

  typedef struct packed {
    logic [1:0] mode;
    logic [6:0] taps;
    logic [4:0] chans;
    logic [8:0] blen;
  } cfg_t;

  typedef struct packed {
    logic clear;
    logic accept;
    logic dec;
    logic mac;
    logic filt;
    logic div;
    logic sqld;
    logic sqrt;
    logic res;
    logic push;
  } cmd_t;

  typedef struct packed {
    logic       clr_last;
    logic       func;
    logic       drop;
    logic       taps_zero;
    logic       k_last;
    logic       pipe_idle;
    logic       closing;
    logic [1:0] mode;
    logic       div_last;
    logic       sqrt_last;
    logic       out_free;
  } status_t;

endpackage

[hdl/mfbi_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module mfbi_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

[hdl/mfbi_ctrl.sv]
// Controller state machine of the FIR block integrator.
// Depends on mfbi_pkg; drives the datapath through cmd_t and reads status_t.
module mfbi_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  mfbi_pkg::status_t st_i,
  output mfbi_pkg::cmd_t    cmd_o
);
  import mfbi_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_CLEAR: if (st_i.clr_last) state_d = S_IDLE;
      S_IDLE:  if (in_valid_i) state_d = S_DEC;
      S_DEC: begin
        if (st_i.func || st_i.drop) state_d = S_IDLE;
        else if (st_i.taps_zero) state_d = S_DONE;
        else state_d = S_MAC;
      end
      S_MAC:   if (st_i.k_last) state_d = S_DRAIN;
      S_DRAIN: if (st_i.pipe_idle) state_d = S_FILT;
      S_FILT: begin
        if (st_i.mode == MODE_NONE) state_d = S_DONE;
        else if (!st_i.closing) state_d = S_IDLE;
        else if (st_i.mode == MODE_MAX) state_d = S_DONE;
        else state_d = S_DIV;
      end
      S_DIV: begin
        if (st_i.div_last) state_d = (st_i.mode == MODE_RMS) ? S_SQLD : S_RES;
      end
      S_SQLD:  state_d = S_SQRT;
      S_SQRT:  if (st_i.sqrt_last) state_d = S_RES;
      S_RES:   state_d = S_DONE;
      S_DONE:  if (st_i.out_free) state_d = S_IDLE;
      default: state_d = S_CLEAR;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_CLEAR: cmd_o.clear = 1'b1;
      S_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
      end
      S_DEC:   cmd_o.dec  = 1'b1;
      S_MAC:   cmd_o.mac  = 1'b1;
      S_DRAIN: ;
      S_FILT:  cmd_o.filt = 1'b1;
      S_DIV:   cmd_o.div  = 1'b1;
      S_SQLD:  cmd_o.sqld = 1'b1;
      S_SQRT:  cmd_o.sqrt = 1'b1;
      S_RES:   cmd_o.res  = 1'b1;
      S_DONE:  cmd_o.push = st_i.out_free;
      default: ;
    endcase
  end

endmodule

[hdl/mfbi_dp.sv]
// Datapath of the FIR block integrator: memories, shared MAC, block
// accumulators, serial divider and square root, output register.
// Depends on mfbi_pkg and mfbi_ram.
module mfbi_dp (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  mfbi_pkg::cfg_t                 cfg_i,
  input  mfbi_pkg::cmd_t                 cmd_i,
  output mfbi_pkg::status_t              st_o,
  input  logic                           func_i,
  input  logic [mfbi_pkg::CH_W-1:0]      channel_i,
  input  logic [mfbi_pkg::TAP_W-1:0]     tap_i,
  input  logic signed [15:0]             value_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [mfbi_pkg::CH_W-1:0]      out_channel_o,
  output logic signed [15:0]             out_value_o,
  output logic                           integrated_o
);
  import mfbi_pkg::*;

  // Latched transaction.
  logic              func_q;
  logic [CH_W-1:0]   ch_q;
  logic [TAP_W-1:0]  tap_q;
  logic signed [15:0] val_q;

  // Clear sweep and per-channel history write pointers.
  logic [MEM_AW-1:0] clr_q;
  logic [TAP_W-1:0]  ptr_q [CHANNELS];
  logic [TAP_W-1:0]  ptr_new;

  // MAC pipeline.
  logic [TAPCNT_W-1:0] k_q;
  logic                rd_v_q, mul_v_q;
  logic signed [31:0]  prod_q;
  logic signed [39:0]  acc_q;
  logic [TAPCNT_W-1:0] taps_eff;
  logic [TAP_W-1:0]    hist_idx;

  // RAM ports.
  logic              coef_we, hist_we;
  logic [MEM_AW-1:0] coef_waddr, hist_waddr, coef_raddr, hist_raddr;
  logic [15:0]       coef_wdata, hist_wdata, coef_rdata, hist_rdata;

  // Block accumulators.
  logic signed [23:0] sum_q   [CHANNELS];
  logic        [39:0] sq_q    [CHANNELS];
  logic signed [15:0] max_q   [CHANNELS];
  logic        [8:0]  cnt_q   [CHANNELS];

  logic signed [39:0] acc_rnd, y_sh;
  logic signed [15:0] y;
  logic signed [23:0] sum_new;
  logic        [39:0] sq_new;
  logic signed [15:0] max_new;
  logic        [9:0]  cnt_inc;
  logic        [8:0]  blen;
  logic               closing;

  // Divider and square root.
  logic [39:0] div_n_q;
  logic [8:0]  div_r_q;
  logic [5:0]  div_cnt_q;
  logic        neg_q;
  logic [9:0]  div_t;
  logic        div_ge;
  logic [39:0] sq_v_q;
  logic [20:0] sq_rem_q;
  logic [19:0] sq_root_q;
  logic [4:0]  sq_cnt_q;
  logic [22:0] sq_rem_n, sq_trial;
  logic        sq_ge;
  logic signed [24:0] mean_s;
  logic signed [15:0] mean_sat, rms_sat;

  // Result and output registers.
  logic               res_integ_q;
  logic signed [15:0] res_val_q;
  logic               out_valid_q;
  logic [CH_W-1:0]    out_ch_q;
  logic signed [15:0] out_val_q;
  logic               out_integ_q;

  assign taps_eff = (cfg_i.taps > TAPCNT_W'(TAPS)) ? TAPCNT_W'(TAPS) : cfg_i.taps;
  assign blen = (cfg_i.blen == '0) ? 9'd1 :
                (cfg_i.blen > 9'(MAX_BLOCK)) ? 9'(MAX_BLOCK) : cfg_i.blen;
  assign ptr_new  = ptr_q[ch_q] + TAP_W'(1);
  // The newest sample sits at the pointer; the oldest tap in use lies taps-1 behind it.
  assign hist_idx = ptr_q[ch_q] + TAP_W'(1) - taps_eff[TAP_W-1:0] + k_q[TAP_W-1:0];

  assign coef_we    = cmd_i.clear || (cmd_i.dec && func_q);
  assign coef_waddr = cmd_i.clear ? clr_q : {ch_q, tap_q};
  assign coef_wdata = cmd_i.clear ? 16'd0 : val_q;
  assign hist_we    = cmd_i.clear || (cmd_i.dec && !func_q && !st_o.drop);
  assign hist_waddr = cmd_i.clear ? clr_q : {ch_q, ptr_new};
  assign hist_wdata = cmd_i.clear ? 16'd0 : val_q;
  assign coef_raddr = {ch_q, k_q[TAP_W-1:0]};
  assign hist_raddr = {ch_q, hist_idx};

  mfbi_ram #(.WIDTH(16), .DEPTH(MEM_DEPTH)) u_coef_ram (
    .clk_i  (clk_i),
    .we_i   (coef_we),
    .waddr_i(coef_waddr),
    .wdata_i(coef_wdata),
    .raddr_i(coef_raddr),
    .rdata_o(coef_rdata)
  );

  mfbi_ram #(.WIDTH(16), .DEPTH(MEM_DEPTH)) u_hist_ram (
    .clk_i  (clk_i),
    .we_i   (hist_we),
    .waddr_i(hist_waddr),
    .wdata_i(hist_wdata),
    .raddr_i(hist_raddr),
    .rdata_o(hist_rdata)
  );

  // Round half up, floor shift, saturate.
  always_comb begin
    acc_rnd = acc_q + 40'sd8192;
    y_sh    = acc_rnd >>> COEF_FRAC_BITS;
    if (y_sh > 40'sd32767) y = 16'sh7fff;
    else if (y_sh < -40'sd32768) y = -16'sh8000;
    else y = y_sh[15:0];
    sum_new = sum_q[ch_q] + 24'(y);
    sq_new  = sq_q[ch_q] + 40'(32'(y) * 32'(y));
    max_new = (y > max_q[ch_q]) ? y : max_q[ch_q];
    cnt_inc = {1'b0, cnt_q[ch_q]} + 10'd1;
    closing = (cnt_inc >= {1'b0, blen});
  end

  always_comb begin
    div_t    = {div_r_q, div_n_q[39]};
    div_ge   = (div_t >= {1'b0, blen});
    sq_rem_n = {sq_rem_q, sq_v_q[39:38]};
    sq_trial = {1'b0, sq_root_q, 2'b01};
    sq_ge    = (sq_rem_n >= sq_trial);
    mean_s   = neg_q ? -25'(div_n_q[23:0]) : 25'(div_n_q[23:0]);
    if (mean_s > 25'sd32767) mean_sat = 16'sh7fff;
    else if (mean_s < -25'sd32768) mean_sat = -16'sh8000;
    else mean_sat = mean_s[15:0];
    rms_sat = (sq_root_q > 20'd32767) ? 16'sh7fff : 16'(sq_root_q);
  end

  always_comb begin
    st_o.clr_last  = (clr_q == MEM_AW'(MEM_DEPTH - 1));
    st_o.func      = func_q;
    st_o.drop      = ({1'b0, ch_q} >= cfg_i.chans);
    st_o.taps_zero = (taps_eff == '0);
    st_o.k_last    = (k_q == taps_eff - TAPCNT_W'(1));
    st_o.pipe_idle = !rd_v_q && !mul_v_q;
    st_o.closing   = closing;
    st_o.mode      = cfg_i.mode;
    st_o.div_last  = (div_cnt_q == 6'd39);
    st_o.sqrt_last = (sq_cnt_q == 5'd19);
    st_o.out_free  = !out_valid_q || out_ready_i;
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      func_q <= func_i;
      ch_q   <= channel_i;
      tap_q  <= tap_i;
      val_q  <= value_i;
    end
    if (rd_v_q) prod_q <= $signed(coef_rdata) * $signed(hist_rdata);
    if (cmd_i.dec) acc_q <= '0;
    else if (mul_v_q) acc_q <= acc_q + 40'(prod_q);
    if (cmd_i.dec) begin
      res_val_q   <= val_q;
      res_integ_q <= 1'b0;
    end else if (cmd_i.filt) begin
      res_val_q   <= (cfg_i.mode == MODE_MAX) ? max_new : y;
      res_integ_q <= (cfg_i.mode != MODE_NONE);
    end else if (cmd_i.res) begin
      res_val_q   <= (cfg_i.mode == MODE_RMS) ? rms_sat : mean_sat;
      res_integ_q <= 1'b1;
    end
    if (cmd_i.filt) begin
      neg_q     <= sum_new[23];
      // The magnitude is zero-extended so the most negative sum stays exact.
      div_n_q   <= (cfg_i.mode == MODE_RMS) ? sq_new
                 : {16'd0, (sum_new[23] ? -sum_new : sum_new)};
      div_r_q   <= '0;
      div_cnt_q <= '0;
    end else if (cmd_i.div) begin
      div_r_q   <= div_ge ? 9'(div_t - {1'b0, blen}) : div_t[8:0];
      div_n_q   <= {div_n_q[38:0], div_ge};
      div_cnt_q <= div_cnt_q + 6'd1;
    end
    if (cmd_i.sqld) begin
      sq_v_q    <= div_n_q;
      sq_rem_q  <= '0;
      sq_root_q <= '0;
      sq_cnt_q  <= '0;
    end else if (cmd_i.sqrt) begin
      sq_v_q    <= {sq_v_q[37:0], 2'b00};
      sq_rem_q  <= sq_ge ? 21'(sq_rem_n - sq_trial) : sq_rem_n[20:0];
      sq_root_q <= {sq_root_q[18:0], sq_ge};
      sq_cnt_q  <= sq_cnt_q + 5'd1;
    end
    if (cmd_i.push) begin
      out_ch_q    <= ch_q;
      out_val_q   <= res_val_q;
      out_integ_q <= res_integ_q;
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q       <= '0;
      k_q         <= '0;
      rd_v_q      <= 1'b0;
      mul_v_q     <= 1'b0;
      out_valid_q <= 1'b0;
      for (int c = 0; c < CHANNELS; c++) begin
        ptr_q[c] <= '0;
        sum_q[c] <= '0;
        sq_q[c]  <= '0;
        max_q[c] <= -16'sh8000;
        cnt_q[c] <= '0;
      end
    end else begin
      if (cmd_i.clear) clr_q <= clr_q + MEM_AW'(1);
      if (hist_we && !cmd_i.clear) ptr_q[ch_q] <= ptr_new;
      if (cmd_i.dec) k_q <= '0;
      else if (cmd_i.mac) k_q <= k_q + TAPCNT_W'(1);
      rd_v_q  <= cmd_i.mac;
      mul_v_q <= rd_v_q;
      if (cmd_i.filt && cfg_i.mode != MODE_NONE) begin
        if (closing) begin
          sum_q[ch_q] <= '0;
          sq_q[ch_q]  <= '0;
          max_q[ch_q] <= -16'sh8000;
          cnt_q[ch_q] <= '0;
        end else begin
          sum_q[ch_q] <= sum_new;
          sq_q[ch_q]  <= sq_new;
          max_q[ch_q] <= max_new;
          cnt_q[ch_q] <= cnt_inc[8:0];
        end
      end
      if (cmd_i.push) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_channel_o = out_ch_q;
  assign out_value_o   = out_val_q;
  assign integrated_o  = out_integ_q;

endmodule

[hdl/multichannel_fir_block_integrator_core.sv]
// Top level of the multichannel FIR block integrator.
// Depends on mfbi_pkg, mfbi_ctrl, mfbi_dp (and through it mfbi_ram).
//
// Usage: input transactions arrive on in_valid_i/in_ready_o with fields
// func_i, channel_i, tap_i and value_i. A transaction with func_i set
// writes one Q2.14 coefficient; otherwise it is a sample for a channel.
// Results leave on out_valid_o/out_ready_i as out_channel_o, out_value_o
// and integrated_o, at most one per sample transaction.
// Flow: one transaction is processed at a time. Each sample runs through
// the single shared multiply-accumulate, which walks the taps one per
// cycle. A block close in mean mode adds a pass through the bit-serial
// divider, and in rms mode through the divider and then the square root.
// After reset both memories are swept to zero, one entry per cycle, so
// in_ready_o stays low until the sweep is done; APB writes are taken
// at any time. The result register lets the next transaction start while
// a result waits; a stalled receiver only holds off the following result.
module multichannel_fir_block_integrator_core (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [3:0]                paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic                      func_i,
  input  logic [mfbi_pkg::CH_W-1:0]  channel_i,
  input  logic [mfbi_pkg::TAP_W-1:0] tap_i,
  input  logic signed [15:0]        value_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [mfbi_pkg::CH_W-1:0]  out_channel_o,
  output logic signed [15:0]        out_value_o,
  output logic                      integrated_o
);
  import mfbi_pkg::*;

  cfg_t    cfg_q;
  cmd_t    cmd;
  status_t st;
  logic    wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  // Configuration registers; only the low bits of each write are kept.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode  <= MODE_MEAN;
      cfg_q.taps  <= '0;
      cfg_q.chans <= 5'd4;
      cfg_q.blen  <= 9'd1;
    end else if (wr_en) begin
      unique case (paddr[3:2])
        REG_MODE:  cfg_q.mode  <= pwdata[1:0];
        REG_TAPS:  cfg_q.taps  <= pwdata[6:0];
        REG_CHANS: cfg_q.chans <= pwdata[4:0];
        REG_BLEN:  cfg_q.blen  <= pwdata[8:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_MODE:  prdata = 32'(cfg_q.mode);
      REG_TAPS:  prdata = 32'(cfg_q.taps);
      REG_CHANS: prdata = 32'(cfg_q.chans);
      REG_BLEN:  prdata = 32'(cfg_q.blen);
      default:   prdata = '0;
    endcase
  end

  mfbi_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .st_i      (st),
    .cmd_o     (cmd)
  );

  mfbi_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .cmd_i        (cmd),
    .st_o         (st),
    .func_i       (func_i),
    .channel_i    (channel_i),
    .tap_i        (tap_i),
    .value_i      (value_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_channel_o(out_channel_o),
    .out_value_o  (out_value_o),
    .integrated_o (integrated_o)
  );

endmodule

[hdl/mfbi_checker.sv]
// Port-level checks for the FIR block integrator, bound to the top level.
// Depends on multichannel_fir_block_integrator_core ports only.
module mfbi_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [15:0] out_value_o
);

  // A waiting result holds its value until taken.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_value_o))
    else $error("result changed while stalled");

  // The block is busy right after accepting a transaction.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("ready stayed high after accept");

  // No result can appear in the cycle right after an accept.
  a_no_instant_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !$rose(out_valid_o))
    else $error("result appeared too early");

endmodule

bind multichannel_fir_block_integrator_core mfbi_checker u_mfbi_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_ready_o (in_ready_o),
  .out_valid_o(out_valid_o),
  .out_ready_i(out_ready_i),
  .out_value_o(out_value_o)
);

[dv/tb.sv]
// Self-checking testbench for multichannel_fir_block_integrator_core.
// Depends on mfbi_pkg and the core; predicts every result in-bench and
// compares it against the DUT output stream.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import mfbi_pkg::*;

  // Clock, reset and DUT ports.
  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [3:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic func_i = 1'b0;
  logic [CH_W-1:0] channel_i = '0;
  logic [TAP_W-1:0] tap_i = '0;
  logic signed [15:0] value_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [CH_W-1:0] out_channel_o;
  logic signed [15:0] out_value_o;
  logic integrated_o;

  always #4 clk_i = ~clk_i;

  multichannel_fir_block_integrator_core dut (.*);

  // One predicted result transaction.
  typedef struct packed {
    logic [CH_W-1:0] chan;
    logic signed [15:0] val;
    logic integ;
  } fir_result_t;

  fir_result_t expected_results[$];
  int mismatches = 0;
  int results_seen = 0;
  int items_sent = 0;
  bit idle_enabled = 1'b1;

  // Shadow copy of the block's configuration and state.
  logic [1:0] sh_mode;
  logic [6:0] sh_taps;
  logic [4:0] sh_chans;
  logic [8:0] sh_blen;
  logic signed [15:0] sh_coef [CHANNELS][TAPS];
  logic signed [15:0] sh_hist [CHANNELS][TAPS];
  logic signed [23:0] sh_sum [CHANNELS];
  logic [39:0] sh_sq [CHANNELS];
  logic signed [15:0] sh_max [CHANNELS];
  logic [8:0] sh_cnt [CHANNELS];

  function automatic logic signed [15:0] sat16(longint v);
    if (v > 32767) return 16'sd32767;
    if (v < -32768) return -16'sd32768;
    return v[15:0];
  endfunction

  // Floor square root, bit by bit.
  function automatic longint unsigned floor_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic void clear_block(int c);
    sh_sum[c] = '0;
    sh_sq[c] = '0;
    sh_max[c] = -16'sd32768;
    sh_cnt[c] = '0;
  endfunction

  function automatic void reset_shadow();
    sh_mode = MODE_MEAN;
    sh_taps = 0;
    sh_chans = 4;
    sh_blen = 1;
    for (int c = 0; c < CHANNELS; c++) begin
      for (int k = 0; k < TAPS; k++) begin
        sh_coef[c][k] = '0;
        sh_hist[c][k] = '0;
      end
      clear_block(c);
    end
  endfunction

  // Advances the shadow state by one item and queues any result.
  function automatic void predict_fir(bit f, int ch, int tp, logic signed [15:0] v);
    int taps, blen;
    longint acc, r, sgn;
    logic signed [15:0] y, res;
    fir_result_t e;
    if (f) begin
      sh_coef[ch][tp] = v;
      return;
    end
    if (ch >= sh_chans) return;
    for (int k = 0; k < TAPS - 1; k++) sh_hist[ch][k] = sh_hist[ch][k + 1];
    sh_hist[ch][TAPS - 1] = v;
    taps = (sh_taps > TAPS) ? TAPS : sh_taps;
    e.chan = CH_W'(ch);
    e.integ = 1'b0;
    if (taps == 0) begin
      e.val = v;
      expected_results.push_back(e);
      return;
    end
    acc = 0;
    for (int k = 0; k < taps; k++)
      acc += longint'(sh_coef[ch][k]) * longint'(sh_hist[ch][TAPS - taps + k]);
    r = acc + (64'sd1 <<< (COEF_FRAC_BITS - 1));
    y = sat16(r >>> COEF_FRAC_BITS);  // arithmetic shift is floor
    if (sh_mode == MODE_NONE) begin
      e.val = y;
      expected_results.push_back(e);
      return;
    end
    sh_sum[ch] = sh_sum[ch] + y;
    sh_sq[ch] = sh_sq[ch] + 40'(longint'(y) * longint'(y));
    if (y > sh_max[ch]) sh_max[ch] = y;
    sh_cnt[ch] = 9'(sh_cnt[ch] + 1);
    blen = (sh_blen == 0) ? 1 : sh_blen;
    if (blen > MAX_BLOCK) blen = MAX_BLOCK;
    if (sh_cnt[ch] < blen) return;
    if (sh_mode == MODE_MEAN) begin
      sgn = longint'(sh_sum[ch]);
      r = ((sgn < 0) ? -sgn : sgn) / blen;
      res = sat16((sgn < 0) ? -r : r);
    end else if (sh_mode == MODE_RMS) begin
      r = floor_sqrt(64'(sh_sq[ch]) / blen);
      res = (r > 32767) ? 16'sd32767 : r[15:0];
    end else begin
      res = sh_max[ch];
    end
    clear_block(ch);
    e.val = res;
    e.integ = 1'b1;
    expected_results.push_back(e);
  endfunction

  // Sends one input transaction, with optional random idle cycles first.
  // Valid drops after each accept; the block is busy then anyway.
  task automatic send_item(bit f, int ch, int tp, logic signed [15:0] v);
    while (idle_enabled && $urandom_range(99) < 13) @(posedge clk_i);
    in_valid_i <= 1'b1;
    func_i <= f;
    channel_i <= CH_W'(ch);
    tap_i <= TAP_W'(tp);
    value_i <= v;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    predict_fir(f, ch, tp, v);
    items_sent++;
    in_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Two-phase APB write; the shadow register tracks it.
  task automatic write_reg(logic [1:0] idx, logic [31:0] d);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= d;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_MODE:  sh_mode = d[1:0];
      REG_TAPS:  sh_taps = d[6:0];
      REG_CHANS: sh_chans = d[4:0];
      default:   sh_blen = d[8:0];
    endcase
    @(posedge clk_i);
  endtask

  // Waits until the result stream drains, then for the slowest block close.
  task automatic drain();
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  task automatic configure(int m, int t, int c, int b);
    drain();
    write_reg(REG_MODE, m);
    write_reg(REG_TAPS, t);
    write_reg(REG_CHANS, c);
    write_reg(REG_BLEN, b);
  endtask

  function automatic logic signed [15:0] rand_value();
    case ($urandom_range(5))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      default: return 16'($urandom());
    endcase
  endfunction

  // Receiver: random back-pressure and the field-by-field comparison.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result ch %0d val %0d", out_channel_o,
                                         out_value_o);
        end else begin
          fir_result_t e;
          e = expected_results.pop_front();
          if (e.chan !== out_channel_o || e.val !== out_value_o
              || e.integ !== integrated_o) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp ch %0d val %0d int %0d, got ch %0d val %0d int %0d",
                       e.chan, e.val, e.integ, out_channel_o, out_value_o, integrated_o);
          end
        end
      end
      out_ready_i <= !(idle_enabled && $urandom_range(99) < 13);
    end
  end

  // Directed: extremes through pass-through, coefficient writes, every mode.
  task automatic test_directed();
    send_item(0, 0, 0, 16'sh7fff);
    send_item(0, 3, 63, 16'sh8000);
    send_item(0, 5, 0, 16'sd1);          // inactive channel, ignored
    configure(MODE_NONE, 2, 16, 1);
    send_item(1, 15, 1, 16'sh7fff);
    send_item(1, 15, 0, 16'sh8000);
    send_item(0, 15, 0, 16'sh7fff);
    send_item(0, 15, 0, 16'sh8000);      // saturation
    send_item(1, 0, 63, 16'sh4000);
    configure(MODE_NONE, 127, 16, 1);   // more taps than exist
    send_item(0, 0, 0, 16'sd100);
    configure(MODE_MEAN, 2, 16, 0);     // block length zero acts as one
    send_item(0, 15, 0, -16'sd7);
    configure(MODE_RMS, 2, 16, 3);
    for (int i = 0; i < 3; i++) send_item(0, 15, 0, 16'sh8000);
    configure(MODE_MAX, 2, 16, 2);
    send_item(0, 15, 0, 16'sd5);
    send_item(0, 15, 0, -16'sd9);
    configure(MODE_MEAN, 2, 16, 511);   // above the maximum block length
    send_item(0, 15, 0, 16'sd1);
  endtask

  // Random: mostly active samples after a burst of coefficient writes.
  task automatic test_random();
    int m, t, c, b;
    for (int phase = 0; phase < 17; phase++) begin
      m = $urandom_range(3);
      t = (phase == 0) ? 64 : (phase == 1) ? 0 : $urandom_range(16);
      c = (phase == 2) ? 1 : $urandom_range(16, 1);
      b = (phase == 3) ? 256 : $urandom_range(6, 1);
      idle_enabled = (phase != 5);
      configure(m, t, c, b);
      for (int i = 0; i < 20; i++)
        send_item(1, $urandom_range(15), $urandom_range(63), 16'($urandom()));
      for (int i = 0; i < 80; i++)
        send_item($urandom_range(19) == 0, $urandom_range(99) < 90 ?
                  $urandom_range(c - 1) : $urandom_range(15), $urandom_range(63),
                  rand_value());
      // Shrink the block length mid-block; blocks close on the next sample.
      if (phase == 4) begin
        drain();
        write_reg(REG_BLEN, 1);
        send_item(0, 0, 0, 16'sd3);
      end
    end
  endtask

  initial begin
    reset_shadow();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_random();
    drain();
    $display("Sent %0d transactions and checked %0d results over all modes and limits.",
             items_sent, results_seen);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("RESULT: ERROR");
    $finish;
  end
endmodule
